[sv/assert_macros.svh]
// assertion macros for the ordered multiset engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[sv/ome_pkg.sv]
// shared types and constants for the ordered multiset engine
package ome_pkg;
   localparam int Capacity = 4096;
   localparam int IdxW = $clog2(Capacity);
   localparam int CntW = IdxW + 1;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_DELETE = 3'd1;
   localparam logic [2:0] ACT_RANK = 3'd2;
   localparam logic [2:0] ACT_KTH = 3'd3;
   localparam logic [2:0] ACT_PRED = 3'd4;
   localparam logic [2:0] ACT_SUCC = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic srch_init; // start binary search
      logic srch_step; // one search step, issue read at mid
      logic srch_upd;  // consume read data
      logic scan_init; // start linear scan at slot 0
      logic scan_rd;   // read slot at scan index
      logic scan_acc;  // accumulate scan data
      logic shup_rd;   // read slot idx-1 for insert shift
      logic shup_wr;   // write read data to idx, idx--
      logic shdn_rd;   // read slot idx+1 for delete shift
      logic shdn_wr;   // write read data to idx, idx++
      logic wr_new;    // write new value at pos, count 1
      logic wr_cnt;    // write adjusted count at pos
      logic rd_pos;    // read slot pos
      logic rd_pm1;    // read slot pos-1
      logic rd_pp1;    // read slot pos+1
      logic fin_ins;   // update totals for insert
      logic fin_del;   // update totals for delete
      logic [1:0] st;  // status to present
      logic ans_rd;    // answer from read value
      logic ans_sum;   // answer from rank sum
      logic present;   // drive response
   } ome_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] act;
      logic srch_done;
      logic pos_lt_n;   // pos < distinct
      logic pos_zero;
      logic pp1_lt_n;   // pos+1 < distinct
      logic hit;        // read value == operand
      logic cnt_max;    // read count all ones
      logic cnt_gt1;
      logic total_max;
      logic full;
      logic k_bad;      // k zero or above total
      logic k_in;       // k <= read count
      logic scan_end;   // scan idx reached distinct / pos
      logic shup_end;   // idx == pos
      logic shdn_end;   // idx reached the reduced distinct count
   } ome_sts_type;
endpackage

[sv/ome_datapath.sv]
// datapath: sorted store memory, search and scan registers
module ome_datapath import ome_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  ome_cmd_type cmd,
   input  logic [2:0] req_action,
   input  logic [30:0] req_operand,
   output ome_sts_type sts,
   output logic [30:0] ans,
   output logic [1:0] st
);
   logic [30:0] mem_val [Capacity];
   logic [31:0] mem_cnt [Capacity];
   logic [30:0] rd_val_ff;
   logic [31:0] rd_cnt_ff;
   logic [2:0] act_ff;
   logic [30:0] opd_ff;
   logic [CntW-1:0] n_ff, n_in;
   logic [31:0] tot_ff, tot_in;
   logic [CntW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [32:0] sum_ff, sum_in;
   logic [31:0] k_ff, k_in;
   logic [30:0] ans_ff, ans_in;
   logic [1:0] st_ff, st_in;
   logic [CntW-1:0] rd_addr;
   logic [CntW-1:0] mid_calc;
   logic rd_en;
   logic wr_en;
   logic [CntW-1:0] wr_addr;
   logic [30:0] wr_val;
   logic [31:0] wr_cnt;

   // midpoint of the current search window
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);

   // read port address select
   always_comb begin
      rd_en = 1'b1;
      rd_addr = mid_calc;
      if (cmd.scan_rd) rd_addr = idx_ff;
      else if (cmd.shup_rd) rd_addr = idx_ff - 1'b1;
      else if (cmd.shdn_rd) rd_addr = idx_ff + 1'b1;
      else if (cmd.rd_pos) rd_addr = lo_ff;
      else if (cmd.rd_pm1) rd_addr = lo_ff - 1'b1;
      else if (cmd.rd_pp1) rd_addr = lo_ff + 1'b1;
      else if (!cmd.srch_step) rd_en = 1'b0;
   end

   // write port select
   always_comb begin
      wr_en = cmd.shup_wr | cmd.shdn_wr | cmd.wr_new | cmd.wr_cnt;
      wr_addr = idx_ff;
      wr_val = rd_val_ff;
      wr_cnt = rd_cnt_ff;
      if (cmd.wr_new) begin
         wr_addr = lo_ff;
         wr_val = opd_ff;
         wr_cnt = 32'd1;
      end else if (cmd.wr_cnt) begin
         wr_addr = lo_ff;
         wr_cnt = (act_ff == ACT_INSERT) ? rd_cnt_ff + 32'd1 : rd_cnt_ff - 32'd1;
      end
   end

   // store memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_val[wr_addr[IdxW-1:0]] <= wr_val;
         mem_cnt[wr_addr[IdxW-1:0]] <= wr_cnt;
      end
      if (rd_en) begin
         rd_val_ff <= mem_val[rd_addr[IdxW-1:0]];
         rd_cnt_ff <= mem_cnt[rd_addr[IdxW-1:0]];
      end
   end

   // working register next values
   always_comb begin
      n_in = n_ff;
      tot_in = tot_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      k_in = k_ff;
      ans_in = ans_ff;
      st_in = st_ff;
      if (cmd.srch_init) begin
         lo_in = '0;
         hi_in = n_ff;
      end
      if (cmd.srch_step) mid_in = mid_calc;
      if (cmd.srch_upd) begin
         if (rd_val_ff < opd_ff) lo_in = mid_ff + 1'b1;
         else hi_in = mid_ff;
      end
      if (cmd.scan_init) begin
         idx_in = '0;
         sum_in = 33'd1;
         k_in = {1'b0, opd_ff};
      end
      if (cmd.scan_acc) begin
         sum_in = sum_ff + {1'b0, rd_cnt_ff};
         if (!(k_ff <= rd_cnt_ff)) k_in = k_ff - rd_cnt_ff;
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.fin_ins) begin
         tot_in = tot_ff + 32'd1;
         // new distinct value: grow the store and shift from the top
         if (!cmd.wr_cnt) begin
            n_in = n_ff + 1'b1;
            idx_in = n_ff;
         end
      end
      if (cmd.fin_del) begin
         tot_in = tot_ff - 32'd1;
         idx_in = lo_ff;
         if (!sts.cnt_gt1) n_in = n_ff - 1'b1;
      end
      if (cmd.shup_wr) idx_in = idx_ff - 1'b1;
      if (cmd.shdn_wr) idx_in = idx_ff + 1'b1;
      if (cmd.present) begin
         st_in = cmd.st;
         ans_in = '0;
         if (cmd.st == ST_OK) begin
            if (cmd.ans_rd) ans_in = rd_val_ff;
            else if (cmd.ans_sum) ans_in = (sum_ff > 33'h7FFFFFFF) ? 31'h7FFFFFFF : sum_ff[30:0];
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
         tot_ff <= '0;
      end else begin
         n_ff <= n_in;
         tot_ff <= tot_in;
      end
      if (cmd.load) begin
         act_ff <= req_action;
         opd_ff <= req_operand;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      k_ff <= k_in;
      ans_ff <= ans_in;
      st_ff <= st_in;
   end

   // status back to controller
   always_comb begin
      sts.act = act_ff;
      sts.srch_done = !(lo_ff < hi_ff);
      sts.pos_lt_n = lo_ff < n_ff;
      sts.pos_zero = lo_ff == '0;
      sts.pp1_lt_n = (lo_ff + 1'b1) < n_ff;
      sts.hit = rd_val_ff == opd_ff;
      sts.cnt_max = &rd_cnt_ff;
      sts.cnt_gt1 = rd_cnt_ff > 32'd1;
      sts.total_max = &tot_ff;
      sts.full = n_ff == CntW'(Capacity);
      sts.k_bad = (opd_ff == '0) || ({1'b0, opd_ff} > tot_ff);
      sts.k_in = k_ff <= rd_cnt_ff;
      sts.scan_end = (act_ff == ACT_RANK) ? (idx_ff == lo_ff) : (idx_ff == n_ff);
      sts.shup_end = idx_ff == lo_ff;
      sts.shdn_end = idx_ff >= n_ff;
   end

   assign ans = ans_ff;
   assign st = st_ff;
endmodule

[sv/ome_ctrl.sv]
// controller: sequences search, scan and shift steps
module ome_ctrl import ome_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  ome_sts_type sts,
   output ome_cmd_type cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_SRCH_W, S_SRCH_U, S_DECIDE, S_POS_W, S_EXEC,
      S_SHUP_R, S_SHUP_W, S_SHDN_R, S_SHDN_W, S_SCAN_R, S_SCAN_W,
      S_SCAN_A, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // a new beat only once the previous result has left
            if (req_valid && !rsp_valid_ff) begin
               cmd.load = 1'b1;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (sts.act == ACT_KTH) begin
               if (sts.k_bad) begin
                  cmd.present = 1'b1;
                  cmd.st = ST_NONE;
                  state_in = S_OUT;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in = S_SCAN_R;
               end
            end else if (sts.act > ACT_SUCC) begin
               cmd.present = 1'b1;
               cmd.st = ST_NONE;
               state_in = S_OUT;
            end else begin
               cmd.srch_init = 1'b1;
               state_in = S_SRCH_W;
            end
         end
         S_SRCH_W: begin
            if (sts.srch_done) begin
               cmd.rd_pos = 1'b1;
               state_in = S_POS_W;
            end else begin
               cmd.srch_step = 1'b1;
               state_in = S_SRCH_U;
            end
         end
         S_SRCH_U: begin
            cmd.srch_upd = 1'b1;
            state_in = S_SRCH_W;
         end
         S_POS_W: begin
            state_in = S_DECIDE;
            if (sts.act == ACT_PRED && !sts.pos_zero) cmd.rd_pm1 = 1'b1;
         end
         S_DECIDE: begin
            state_in = S_OUT;
            cmd.present = 1'b1;
            case (sts.act)
               ACT_INSERT: begin
                  cmd.present = 1'b0;
                  if (sts.total_max) begin
                     cmd.present = 1'b1;
                     cmd.st = ST_FULL;
                  end else if (sts.pos_lt_n && sts.hit) begin
                     if (sts.cnt_max) begin
                        cmd.present = 1'b1;
                        cmd.st = ST_FULL;
                     end else begin
                        cmd.wr_cnt = 1'b1;
                        cmd.fin_ins = 1'b1;
                        cmd.present = 1'b1;
                        cmd.st = ST_OK;
                     end
                  end else if (sts.full) begin
                     cmd.present = 1'b1;
                     cmd.st = ST_FULL;
                  end else begin
                     cmd.fin_ins = 1'b1;
                     state_in = S_SHUP_R;
                  end
               end
               ACT_DELETE: begin
                  if (!(sts.pos_lt_n && sts.hit)) begin
                     cmd.st = ST_NONE;
                  end else if (sts.cnt_gt1) begin
                     cmd.wr_cnt = 1'b1;
                     cmd.fin_del = 1'b1;
                     cmd.st = ST_OK;
                  end else begin
                     cmd.present = 1'b0;
                     cmd.fin_del = 1'b1;
                     state_in = S_SHDN_R;
                  end
               end
               ACT_RANK: begin
                  cmd.present = 1'b0;
                  cmd.scan_init = 1'b1;
                  state_in = S_SCAN_R;
               end
               ACT_PRED: begin
                  cmd.st = sts.pos_zero ? ST_NONE : ST_OK;
                  cmd.ans_rd = 1'b1;
               end
               ACT_SUCC: begin
                  if (sts.pos_lt_n && sts.hit) begin
                     if (sts.pp1_lt_n) begin
                        cmd.present = 1'b0;
                        cmd.rd_pp1 = 1'b1;
                        state_in = S_EXEC;
                     end else cmd.st = ST_NONE;
                  end else begin
                     cmd.st = sts.pos_lt_n ? ST_OK : ST_NONE;
                     cmd.ans_rd = 1'b1;
                  end
               end
               default: cmd.st = ST_NONE;
            endcase
         end
         S_EXEC: begin
            cmd.present = 1'b1;
            cmd.st = ST_OK;
            cmd.ans_rd = 1'b1;
            state_in = S_OUT;
         end
         S_SHUP_R: begin
            if (sts.shup_end) begin
               cmd.wr_new = 1'b1;
               cmd.present = 1'b1;
               cmd.st = ST_OK;
               state_in = S_OUT;
            end else begin
               cmd.shup_rd = 1'b1;
               state_in = S_SHUP_W;
            end
         end
         S_SHUP_W: begin
            cmd.shup_wr = 1'b1;
            state_in = S_SHUP_R;
         end
         S_SHDN_R: begin
            if (sts.shdn_end) begin
               cmd.present = 1'b1;
               cmd.st = ST_OK;
               state_in = S_OUT;
            end else begin
               cmd.shdn_rd = 1'b1;
               state_in = S_SHDN_W;
            end
         end
         S_SHDN_W: begin
            cmd.shdn_wr = 1'b1;
            state_in = S_SHDN_R;
         end
         S_SCAN_R: begin
            if (sts.scan_end) begin
               cmd.present = 1'b1;
               cmd.st = (sts.act == ACT_RANK) ? ST_OK : ST_NONE;
               cmd.ans_sum = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in = S_SCAN_W;
            end
         end
         S_SCAN_W: state_in = S_SCAN_A;
         S_SCAN_A: begin
            if (sts.act == ACT_KTH && sts.k_in) begin
               cmd.present = 1'b1;
               cmd.st = ST_OK;
               cmd.ans_rd = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.scan_acc = 1'b1;
               state_in = S_SCAN_R;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // no present in S_OUT, so the answer register holds while the result waits
      if (state_ff == S_OUT) cmd.present = 1'b0;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
endmodule

[sv/ordered_multiset_engine.sv]
// top level of the ordered multiset engine
//  channel | ports                                 | direction
//  request | req_valid req_ready req_action req_operand | in
//  result  | rsp_valid rsp_ready rsp_answer rsp_status  | out
// search based actions run a binary search over the distinct values
// insert and delete of a new or last copy also shift each stored slot past the position by one
// rank and kth walk the store slot by slot through the single read port
// synchronous reset empties the store at once; no clearing pass
// the next request is taken once the previous result beat has been accepted
`include "assert_macros.svh"
module ordered_multiset_engine import ome_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_action,
   input  logic [30:0] req_operand,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [30:0] rsp_answer,
   output logic [1:0] rsp_status
);
   ome_cmd_type cmd;
   ome_sts_type sts;

   ome_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   ome_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_action(req_action),
      .req_operand(req_operand), .sts(sts), .ans(rsp_answer), .st(rsp_status)
   );

   // checks
   `ASSERT_IMPLIES(a_nonok_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_answer == '0)
   `ASSERT_IMPLIES(a_st_range, clock, reset, rsp_valid, rsp_status != 2'd3)
   `ASSERT_NEXT(a_load_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule
